// File: design/fha_pkg.sv
// Shared types, constants and helper functions for the flame histogram accumulator.
// Used by every module under design/; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package fha_pkg;

	localparam int SUB_W       = 256;
	localparam int SUB_H       = 256;
	localparam int MAX_DENSITY = 4;
	localparam int COUNT_BITS  = 32;

	localparam int COL_BITS    = $clog2(SUB_W);
	localparam int ROW_BITS    = $clog2(SUB_H);
	localparam int ADDR_BITS   = COL_BITS + ROW_BITS;
	localparam int COLOR_BITS  = 24;
	localparam int CELL_BITS   = COUNT_BITS + COLOR_BITS;
	localparam int DSQ_BITS    = $clog2(MAX_DENSITY * MAX_DENSITY + 1);
	localparam int SUM_BITS    = 8 + $clog2(MAX_DENSITY * MAX_DENSITY);
	localparam int F_BITS      = COUNT_BITS + $clog2(MAX_DENSITY * MAX_DENSITY);
	localparam int LOG_INT_BITS = $clog2(F_BITS);
	localparam int LOG_BITS    = LOG_INT_BITS + 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	// Reciprocal of nine for the 3x3 supersampling average, exact below 2^17.
	localparam int RECIP9_SHIFT = 20;
	localparam logic [16:0] RECIP9 = 17'(((1 << RECIP9_SHIFT) + 8) / 9);

	// Configuration register indexes.
	localparam logic [2:0] REG_X_START    = 3'd0;
	localparam logic [2:0] REG_X_END      = 3'd1;
	localparam logic [2:0] REG_Y_START    = 3'd2;
	localparam logic [2:0] REG_Y_END      = 3'd3;
	localparam logic [2:0] REG_OUT_WIDTH  = 3'd4;
	localparam logic [2:0] REG_OUT_HEIGHT = 3'd5;
	localparam logic [2:0] REG_DENSITY    = 3'd6;
	localparam logic [2:0] REG_BACKGROUND = 3'd7;

	typedef enum logic [1:0] {
		CMD_PLOT,
		CMD_QUERY,
		CMD_BLACK
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [ADDR_BITS-1:0]   addr;
		logic [COLOR_BITS-1:0]  color;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] x_start;
		logic signed [31:0] x_end;
		logic signed [31:0] y_start;
		logic signed [31:0] y_end;
		logic [2:0]         dens;
		logic [8:0]         eff_w;
		logic [8:0]         eff_h;
		logic [8:0]         sub_w;
		logic [8:0]         sub_h;
		logic [COLOR_BITS-1:0] bg;
	} cfg_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_CLEAR,
		B_IDLE,
		B_PLOT_WR,
		B_Q_WALK,
		B_Q_DRAIN,
		B_EVAL,
		B_LOG_F,
		B_LOG_D,
		B_LOG_L,
		B_RATIO,
		B_DIV,
		B_GAMMA,
		B_SCALE1,
		B_SCALE2
	} back_state_t;

	typedef enum logic [1:0] {
		L_IDLE,
		L_NORM,
		L_SQR
	} log_state_t;

	function automatic logic [2:0] eff_density(logic [2:0] d);
		logic [2:0] r;
		r = d;
		if (d == 3'd0)
			r = 3'd1;
		if (d > 3'(MAX_DENSITY))
			r = 3'(MAX_DENSITY);
		return r;
	endfunction

	function automatic logic [8:0] width_limit(logic [2:0] d);
		logic [8:0] r;
		case (d)
			3'd1: r = 9'(SUB_W);
			3'd2: r = 9'(SUB_W / 2);
			3'd3: r = 9'(SUB_W / 3);
			default: r = 9'(SUB_W / 4);
		endcase
		return r;
	endfunction

	function automatic logic [8:0] height_limit(logic [2:0] d);
		logic [8:0] r;
		case (d)
			3'd1: r = 9'(SUB_H);
			3'd2: r = 9'(SUB_H / 2);
			3'd3: r = 9'(SUB_H / 3);
			default: r = 9'(SUB_H / 4);
		endcase
		return r;
	endfunction

	function automatic logic [8:0] clamp_side(logic [8:0] v, logic [8:0] lim);
		logic [8:0] r;
		r = v;
		if (v == 9'd0)
			r = 9'd1;
		if (v > lim)
			r = lim;
		return r;
	endfunction

	// Gamma table: entry a is the largest s in 0..256 with s^11 <= a^5 * 256^6,
	// i.e. a^(1/2.2) in Q0.8. Built at elaboration.
	typedef logic [8:0] gamma_tab_t [0:256];

	function automatic gamma_tab_t build_gamma();
		gamma_tab_t   t;
		logic [127:0] rhs;
		logic [127:0] lhs;
		int           lo;
		int           hi;
		int           mid;
		for (int a = 0; a <= 256; a++) begin
			rhs = 128'(1) << 48;
			for (int i = 0; i < 5; i++)
				rhs = rhs * 128'(a);
			lo = 0;
			hi = 256;
			while (lo < hi) begin
				mid = (lo + hi + 1) >> 1;
				lhs = 128'(1);
				for (int i = 0; i < 11; i++)
					lhs = lhs * 128'(mid);
				if (lhs <= rhs)
					lo = mid;
				else
					hi = mid - 1;
			end
			t[a] = 9'(lo);
		end
		return t;
	endfunction

	localparam gamma_tab_t GAMMA_TAB = build_gamma();

endpackage
`default_nettype wire

// File: design/flame_histogram_accumulator.sv
// Flame histogram accumulator top level: configuration registers, front, queue, back.
// Plot: busy in the front while it multiplies, runs a 9-step divider and pushes, then the
// back reads and rewrites the cell; a point outside the window is dropped and not queued.
// Query: the back reads the d*d cells of the pixel and, if their count sum exceeds d*d,
// runs three log2 passes and at most an 8-step divider; a pixel outside the image is black.
// Reset and every register write start a clear sweep of all 65536 cells with busy high;
// results are one-cycle result_valid pulses that the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module flame_histogram_accumulator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        kind,
	input  wire logic [31:0] point_x,
	input  wire logic [31:0] point_y,
	input  wire logic [7:0]  color_red,
	input  wire logic [7:0]  color_green,
	input  wire logic [7:0]  color_blue,
	input  wire logic [7:0]  pixel_col,
	input  wire logic [7:0]  pixel_row,
	output logic             result_valid,
	output logic [7:0]       pixel_red,
	output logic [7:0]       pixel_green,
	output logic [7:0]       pixel_blue,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	// Raw configuration registers, truncated to their field widths on write.
	logic [31:0] x_start_q, x_end_q, y_start_q, y_end_q;
	logic [8:0]  out_width_q, out_height_q;
	logic [2:0]  density_q;
	logic [23:0] background_q;

	logic          cfg_wr;
	fha_pkg::cfg_t cfg;
	logic [2:0]    d_eff;
	logic [8:0]    w_eff, h_eff;
	logic [11:0]   sub_w_full, sub_h_full;

	logic          front_busy;
	logic          clearing;
	logic          push, full, pop, empty;
	fha_pkg::cmd_t push_cmd, head;

	// The register port never stalls; software only writes while the block is idle (not enforced here).
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_start_q    <= 32'hFFFE_0000;
			x_end_q      <= 32'h0002_0000;
			y_start_q    <= 32'hFFFE_0000;
			y_end_q      <= 32'h0002_0000;
			out_width_q  <= 9'd64;
			out_height_q <= 9'd64;
			density_q    <= 3'd4;
			background_q <= 24'd0;
		end else if (cfg_wr) begin
			case (cfg_index)
				fha_pkg::REG_X_START:    x_start_q    <= cfg_data;
				fha_pkg::REG_X_END:      x_end_q      <= cfg_data;
				fha_pkg::REG_Y_START:    y_start_q    <= cfg_data;
				fha_pkg::REG_Y_END:      y_end_q      <= cfg_data;
				fha_pkg::REG_OUT_WIDTH:  out_width_q  <= cfg_data[8:0];
				fha_pkg::REG_OUT_HEIGHT: out_height_q <= cfg_data[8:0];
				fha_pkg::REG_DENSITY:    density_q    <= cfg_data[2:0];
				fha_pkg::REG_BACKGROUND: background_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Effective sizes: density clamps to 1..4, the output size so that the
	// supersampled grid fits the 256x256 cell store.
	assign d_eff      = fha_pkg::eff_density(density_q);
	assign w_eff      = fha_pkg::clamp_side(out_width_q, fha_pkg::width_limit(d_eff));
	assign h_eff      = fha_pkg::clamp_side(out_height_q, fha_pkg::height_limit(d_eff));
	assign sub_w_full = w_eff * d_eff;
	assign sub_h_full = h_eff * d_eff;

	always_comb begin
		cfg.x_start = $signed(x_start_q);
		cfg.x_end   = $signed(x_end_q);
		cfg.y_start = $signed(y_start_q);
		cfg.y_end   = $signed(y_end_q);
		cfg.dens    = d_eff;
		cfg.eff_w   = w_eff;
		cfg.eff_h   = h_eff;
		cfg.sub_w   = sub_w_full[8:0];
		cfg.sub_h   = sub_h_full[8:0];
		cfg.bg      = background_q;
	end

	// The front takes a new item as soon as its previous command is queued,
	// so plots keep flowing while the back is busy with a query, until the two-entry queue is full.
	fha_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.hold        (clearing),
		.start       (start),
		.busy        (front_busy),
		.kind        (kind),
		.point_x     (point_x),
		.point_y     (point_y),
		.color_red   (color_red),
		.color_green (color_green),
		.color_blue  (color_blue),
		.pixel_col   (pixel_col),
		.pixel_row   (pixel_row),
		.push        (push),
		.push_cmd    (push_cmd),
		.full        (full)
	);

	assign busy = front_busy;

	fha_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	// The back executes commands in queue order, so a query always sees every
	// plot that was accepted before it.
	fha_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.restart      (cfg_wr),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.clearing     (clearing),
		.result_valid (result_valid),
		.pixel_red    (pixel_red),
		.pixel_green  (pixel_green),
		.pixel_blue   (pixel_blue)
	);

endmodule
`default_nettype wire

// File: design/fha_queue.sv
// Two-entry command queue between the front and back parts.
// Depends on fha_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none
module fha_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire fha_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output fha_pkg::cmd_t      head,
	output logic               empty
);

	fha_pkg::cmd_t ents_q [fha_pkg::QUEUE_DEPTH];
	logic [fha_pkg::QPTR_BITS-1:0] wptr_q, rptr_q;
	logic [fha_pkg::QPTR_BITS:0]   cnt_q;

	assign full  = (cnt_q == (fha_pkg::QPTR_BITS+1)'(fha_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = ents_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push && !full)
				wptr_q <= wptr_q + 1'b1;
			if (pop && !empty)
				rptr_q <= rptr_q + 1'b1;
			if ((push && !full) && !(pop && !empty))
				cnt_q <= cnt_q + 1'b1;
			else if (!(push && !full) && (pop && !empty))
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full)
			ents_q[wptr_q] <= push_cmd;
	end

endmodule
`default_nettype wire

// File: design/fha_front.sv
// Front part: accepts items, checks the window, maps points (with a bit-serial divider)
// and query pixels to a cell address and queues commands. Depends on fha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fha_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire fha_pkg::cfg_t cfg,
	input  wire logic          hold,
	input  wire logic          start,
	output logic               busy,
	input  wire logic          kind,
	input  wire logic [31:0]   point_x,
	input  wire logic [31:0]   point_y,
	input  wire logic [7:0]    color_red,
	input  wire logic [7:0]    color_green,
	input  wire logic [7:0]    color_blue,
	input  wire logic [7:0]    pixel_col,
	input  wire logic [7:0]    pixel_row,
	output logic               push,
	output fha_pkg::cmd_t      push_cmd,
	input  wire logic          full
);

	fha_pkg::front_state_t state_q, state_d;

	logic        accept;
	logic        in_win;
	logic [32:0] numx, denx, numy, deny;
	logic [32:0] absnx, absdx, absny, absdy;
	logic        zx, zy;
	logic        is_black;
	logic [10:0] base_row, base_col;

	logic [32:0] unx_q, udx_q, uny_q, udy_q;
	logic        zx_q, zy_q;
	logic [41:0] remx_q, dvx_q, remy_q, dvy_q;
	logic [41:0] mulx, muly;
	logic [8:0]  qx_q, qy_q;
	logic [3:0]  step_q;
	logic        gex, gey;
	logic [8:0]  qx_fin, qy_fin;
	logic [7:0]  col, row;
	fha_pkg::cmd_t cmd_q;

	assign busy   = (state_q != fha_pkg::F_IDLE) || hold;
	assign accept = start && !busy;

	assign in_win = ((($signed(point_x) >= cfg.x_start) && ($signed(point_x) <= cfg.x_end)) ||
			(($signed(point_x) >= cfg.x_end) && ($signed(point_x) <= cfg.x_start))) &&
			((($signed(point_y) >= cfg.y_start) && ($signed(point_y) <= cfg.y_end)) ||
			(($signed(point_y) >= cfg.y_end) && ($signed(point_y) <= cfg.y_start)));

	assign numx  = {point_x[31], point_x} - {cfg.x_start[31], cfg.x_start};
	assign denx  = {cfg.x_end[31], cfg.x_end} - {cfg.x_start[31], cfg.x_start};
	assign numy  = {point_y[31], point_y} - {cfg.y_start[31], cfg.y_start};
	assign deny  = {cfg.y_end[31], cfg.y_end} - {cfg.y_start[31], cfg.y_start};
	assign absnx = numx[32] ? -numx : numx;
	assign absdx = denx[32] ? -denx : denx;
	assign absny = numy[32] ? -numy : numy;
	assign absdy = deny[32] ? -deny : deny;
	// A degenerate axis, or a point on the wrong side of the start edge, maps to zero.
	assign zx = (denx == '0) || ((numx[32] != denx[32]) && (numx != '0));
	assign zy = (deny == '0) || ((numy[32] != deny[32]) && (numy != '0));

	assign is_black = ({1'b0, pixel_col} >= cfg.eff_w) || ({1'b0, pixel_row} >= cfg.eff_h);
	assign base_row = pixel_row * cfg.dens;
	assign base_col = pixel_col * cfg.dens;

	assign mulx = unx_q * cfg.sub_w;
	assign muly = uny_q * cfg.sub_h;

	assign gex    = remx_q >= dvx_q;
	assign gey    = remy_q >= dvy_q;
	assign qx_fin = {qx_q[7:0], gex};
	assign qy_fin = {qy_q[7:0], gey};
	assign col = zx_q ? 8'd0 : ((qx_fin > cfg.sub_w - 9'd1) ? 8'(cfg.sub_w - 9'd1) : qx_fin[7:0]);
	assign row = zy_q ? 8'd0 : ((qy_fin > cfg.sub_h - 9'd1) ? 8'(cfg.sub_h - 9'd1) : qy_fin[7:0]);

	assign push     = (state_q == fha_pkg::F_PUSH) && !full;
	assign push_cmd = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fha_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fha_pkg::F_IDLE: begin
				if (accept) begin
					if (kind)
						state_d = fha_pkg::F_PUSH;
					else if (in_win)
						state_d = fha_pkg::F_MUL;
				end
			end
			fha_pkg::F_MUL: state_d = fha_pkg::F_DIV;
			fha_pkg::F_DIV: begin
				if (step_q == 4'd8)
					state_d = fha_pkg::F_PUSH;
			end
			fha_pkg::F_PUSH: begin
				if (!full)
					state_d = fha_pkg::F_IDLE;
			end
			default: state_d = fha_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fha_pkg::F_IDLE: begin
				if (accept) begin
					unx_q <= absnx;
					udx_q <= absdx;
					uny_q <= absny;
					udy_q <= absdy;
					zx_q  <= zx;
					zy_q  <= zy;
					cmd_q.color <= {color_red, color_green, color_blue};
					if (!kind) begin
						cmd_q.kind <= fha_pkg::CMD_PLOT;
					end else if (is_black) begin
						cmd_q.kind <= fha_pkg::CMD_BLACK;
					end else begin
						cmd_q.kind <= fha_pkg::CMD_QUERY;
						cmd_q.addr <= {base_row[7:0], base_col[7:0]};
					end
				end
			end
			fha_pkg::F_MUL: begin
				remx_q <= mulx;
				remy_q <= muly;
				dvx_q  <= {1'b0, udx_q, 8'b0};
				dvy_q  <= {1'b0, udy_q, 8'b0};
				qx_q   <= '0;
				qy_q   <= '0;
				step_q <= '0;
			end
			fha_pkg::F_DIV: begin
				remx_q <= gex ? remx_q - dvx_q : remx_q;
				remy_q <= gey ? remy_q - dvy_q : remy_q;
				dvx_q  <= dvx_q >> 1;
				dvy_q  <= dvy_q >> 1;
				qx_q   <= qx_fin;
				qy_q   <= qy_fin;
				step_q <= step_q + 4'd1;
				if (step_q == 4'd8)
					cmd_q.addr <= {row, col};
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: design/fha_log2.sv
// Multi-cycle log2 unit giving Q6.8 results: a one-bit-per-cycle normalizing
// shift, then eight squaring steps of a 16-bit mantissa. Depends on fha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fha_log2 (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [fha_pkg::F_BITS-1:0]    x,
	output logic                               done,
	output logic [fha_pkg::LOG_BITS-1:0]       result
);

	fha_pkg::log_state_t state_q, state_d;

	logic [fha_pkg::F_BITS-1:0]       w_q;
	logic [fha_pkg::LOG_INT_BITS-1:0] n_q;
	logic [15:0]                      m_q;
	logic [7:0]                       frac_q;
	logic [2:0]                       cnt_q;
	logic                             done_q;
	logic [31:0]                      sq;
	logic [16:0]                      s17;

	assign sq     = m_q * m_q;
	assign s17    = sq[31:15];
	assign done   = done_q;
	assign result = {n_q, frac_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fha_pkg::L_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == fha_pkg::L_SQR) && (cnt_q == 3'd7);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fha_pkg::L_IDLE: begin
				if (start)
					state_d = fha_pkg::L_NORM;
			end
			fha_pkg::L_NORM: begin
				if (w_q[fha_pkg::F_BITS-1] || n_q == '0)
					state_d = fha_pkg::L_SQR;
			end
			fha_pkg::L_SQR: begin
				if (cnt_q == 3'd7)
					state_d = fha_pkg::L_IDLE;
			end
			default: state_d = fha_pkg::L_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fha_pkg::L_IDLE: begin
				if (start) begin
					w_q <= x;
					n_q <= fha_pkg::LOG_INT_BITS'(fha_pkg::F_BITS - 1);
				end
			end
			fha_pkg::L_NORM: begin
				if (w_q[fha_pkg::F_BITS-1] || n_q == '0) begin
					m_q    <= w_q[fha_pkg::F_BITS-1 -: 16];
					frac_q <= '0;
					cnt_q  <= '0;
				end else begin
					w_q <= w_q << 1;
					n_q <= n_q - 1'b1;
				end
			end
			fha_pkg::L_SQR: begin
				cnt_q <= cnt_q + 3'd1;
				if (s17[16]) begin
					m_q    <= s17[16:1];
					frac_q <= {frac_q[6:0], 1'b1};
				end else begin
					m_q    <= s17[15:0];
					frac_q <= {frac_q[6:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: design/fha_back.sv
// Back part: owns the cell store, clears it, does plot read-modify-writes,
// walks query cells and tone maps them. Depends on fha_pkg and fha_log2.
`timescale 1ns / 1ps
`default_nettype none
module fha_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire fha_pkg::cfg_t cfg,
	input  wire logic          restart,
	input  wire logic          empty,
	input  wire fha_pkg::cmd_t head,
	output logic               pop,
	output logic               clearing,
	output logic               result_valid,
	output logic [7:0]         pixel_red,
	output logic [7:0]         pixel_green,
	output logic [7:0]         pixel_blue
);

	fha_pkg::back_state_t state_q, state_d;

	logic [fha_pkg::CELL_BITS-1:0] cell_mem [2**fha_pkg::ADDR_BITS];
	logic [fha_pkg::CELL_BITS-1:0] rd_data_q;
	logic                          rd_en, we;
	logic [fha_pkg::ADDR_BITS-1:0] rd_addr, wa;
	logic [fha_pkg::CELL_BITS-1:0] wd;

	logic [fha_pkg::ADDR_BITS-1:0]  clr_q;
	logic [fha_pkg::COUNT_BITS-1:0] largest_q;
	fha_pkg::cmd_t                  cur_q;

	logic [1:0] di_q, dj_q, dlast;
	logic       pend_q;
	logic [fha_pkg::SUM_BITS-1:0] sum_r_q, sum_g_q, sum_b_q;
	logic [fha_pkg::F_BITS-1:0]   f_q;
	logic [fha_pkg::DSQ_BITS-1:0] dd;
	logic [fha_pkg::ADDR_BITS-1:0] walk_addr;

	logic [fha_pkg::COUNT_BITS-1:0] old_cnt, new_cnt;
	logic [fha_pkg::COLOR_BITS-1:0] old_col, blend;
	logic [8:0] br, bgr, bb;

	logic                          log_start, log_done;
	logic [fha_pkg::F_BITS-1:0]    log_x;
	logic [fha_pkg::LOG_BITS-1:0]  log_res;
	logic [fha_pkg::LOG_BITS-1:0]  lf_q, ld_q, ll_q, r_q;
	logic signed [fha_pkg::LOG_BITS:0] lm;
	logic [fha_pkg::LOG_BITS:0]    r2;
	logic                          rge;
	logic [8:0]                    a_q, g_q;
	logic [2:0]                    step_q;
	logic [20:0]                   prod_r_s1, prod_g_s1, prod_b_s1;

	function automatic logic [7:0] tone_out(logic [20:0] prod, logic [2:0] d,
			logic [fha_pkg::DSQ_BITS-1:0] dsq);
		logic [21:0] num;
		logic [12:0] x;
		logic [29:0] xm;
		logic [12:0] v;
		num = {prod, 1'b0} + {9'd0, dsq, 8'd0};
		x   = num[21:9];
		xm  = x * fha_pkg::RECIP9;
		case (d)
			3'd1: v = x;
			3'd2: v = x >> 2;
			3'd3: v = 13'(xm >> fha_pkg::RECIP9_SHIFT);
			default: v = x >> 4;
		endcase
		return (v > 13'd255) ? 8'd255 : v[7:0];
	endfunction

	assign clearing = (state_q == fha_pkg::B_CLEAR);
	assign dd       = fha_pkg::DSQ_BITS'(cfg.dens * cfg.dens);
	assign dlast    = 2'(cfg.dens - 3'd1);
	assign walk_addr = {cur_q.addr[fha_pkg::ADDR_BITS-1 -: fha_pkg::ROW_BITS] +
			fha_pkg::ROW_BITS'(di_q),
			cur_q.addr[fha_pkg::COL_BITS-1:0] + fha_pkg::COL_BITS'(dj_q)};

	assign old_cnt = rd_data_q[fha_pkg::CELL_BITS-1 -: fha_pkg::COUNT_BITS];
	assign old_col = rd_data_q[fha_pkg::COLOR_BITS-1:0];
	assign new_cnt = (old_cnt == '1) ? old_cnt : old_cnt + 1'b1;
	assign br  = {1'b0, old_col[23:16]} + {1'b0, cur_q.color[23:16]};
	assign bgr = {1'b0, old_col[15:8]} + {1'b0, cur_q.color[15:8]};
	assign bb  = {1'b0, old_col[7:0]} + {1'b0, cur_q.color[7:0]};
	assign blend = {br[8:1], bgr[8:1], bb[8:1]};

	assign lm  = $signed({1'b0, lf_q}) - $signed({1'b0, ld_q});
	assign r2  = {r_q, 1'b0};
	assign rge = r2 >= {1'b0, ll_q};

	fha_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.x      (log_x),
		.done   (log_done),
		.result (log_res)
	);

	always_ff @(posedge clk) begin
		if (we)
			cell_mem[wa] <= wd;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= cell_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fha_pkg::B_CLEAR;
		end else if (restart) begin
			state_q <= fha_pkg::B_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = head.addr;
		we        = 1'b0;
		wa        = clr_q;
		wd        = {{fha_pkg::COUNT_BITS{1'b0}}, cfg.bg};
		log_start = 1'b0;
		log_x     = f_q;
		case (state_q)
			fha_pkg::B_CLEAR: begin
				we = 1'b1;
				if (clr_q == '1)
					state_d = fha_pkg::B_IDLE;
			end
			fha_pkg::B_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					case (head.kind)
						fha_pkg::CMD_PLOT: begin
							rd_en   = 1'b1;
							state_d = fha_pkg::B_PLOT_WR;
						end
						fha_pkg::CMD_QUERY: state_d = fha_pkg::B_Q_WALK;
						default: state_d = fha_pkg::B_IDLE;
					endcase
				end
			end
			fha_pkg::B_PLOT_WR: begin
				we      = 1'b1;
				wa      = cur_q.addr;
				wd      = {new_cnt, blend};
				state_d = fha_pkg::B_IDLE;
			end
			fha_pkg::B_Q_WALK: begin
				rd_en   = 1'b1;
				rd_addr = walk_addr;
				if (di_q == dlast && dj_q == dlast)
					state_d = fha_pkg::B_Q_DRAIN;
			end
			fha_pkg::B_Q_DRAIN: state_d = fha_pkg::B_EVAL;
			fha_pkg::B_EVAL: begin
				if (f_q <= fha_pkg::F_BITS'(dd)) begin
					state_d = fha_pkg::B_SCALE1;
				end else begin
					log_start = 1'b1;
					state_d   = fha_pkg::B_LOG_F;
				end
			end
			fha_pkg::B_LOG_F: begin
				if (log_done) begin
					log_start = 1'b1;
					log_x     = fha_pkg::F_BITS'(dd);
					state_d   = fha_pkg::B_LOG_D;
				end
			end
			fha_pkg::B_LOG_D: begin
				if (log_done) begin
					log_start = 1'b1;
					log_x     = fha_pkg::F_BITS'(largest_q);
					state_d   = fha_pkg::B_LOG_L;
				end
			end
			fha_pkg::B_LOG_L: begin
				if (log_done)
					state_d = fha_pkg::B_RATIO;
			end
			fha_pkg::B_RATIO: begin
				if (lm[fha_pkg::LOG_BITS] || lm == '0 ||
						lm[fha_pkg::LOG_BITS-1:0] >= ll_q)
					state_d = fha_pkg::B_GAMMA;
				else
					state_d = fha_pkg::B_DIV;
			end
			fha_pkg::B_DIV: begin
				if (step_q == 3'd7)
					state_d = fha_pkg::B_GAMMA;
			end
			fha_pkg::B_GAMMA:  state_d = fha_pkg::B_SCALE1;
			fha_pkg::B_SCALE1: state_d = fha_pkg::B_SCALE2;
			fha_pkg::B_SCALE2: state_d = fha_pkg::B_IDLE;
			default: state_d = fha_pkg::B_IDLE;
		endcase
	end

	// Control registers: clear sweep position, largest count, result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			largest_q    <= fha_pkg::COUNT_BITS'(2);
			result_valid <= 1'b0;
			pend_q       <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			pend_q       <= (state_q == fha_pkg::B_Q_WALK);
			if (restart) begin
				clr_q     <= '0;
				largest_q <= fha_pkg::COUNT_BITS'(2);
			end else begin
				if (state_q == fha_pkg::B_CLEAR)
					clr_q <= clr_q + 1'b1;
				if (state_q == fha_pkg::B_PLOT_WR && new_cnt > largest_q)
					largest_q <= new_cnt;
				if (state_q == fha_pkg::B_SCALE2)
					result_valid <= 1'b1;
				if (state_q == fha_pkg::B_IDLE && !empty && head.kind == fha_pkg::CMD_BLACK)
					result_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			sum_r_q <= sum_r_q + fha_pkg::SUM_BITS'(rd_data_q[23:16]);
			sum_g_q <= sum_g_q + fha_pkg::SUM_BITS'(rd_data_q[15:8]);
			sum_b_q <= sum_b_q + fha_pkg::SUM_BITS'(rd_data_q[7:0]);
			f_q     <= f_q + fha_pkg::F_BITS'(old_cnt);
		end
		case (state_q)
			fha_pkg::B_IDLE: begin
				if (!empty) begin
					cur_q   <= head;
					di_q    <= '0;
					dj_q    <= '0;
					sum_r_q <= '0;
					sum_g_q <= '0;
					sum_b_q <= '0;
					f_q     <= '0;
					pixel_red   <= 8'd0;
					pixel_green <= 8'd0;
					pixel_blue  <= 8'd0;
				end
			end
			fha_pkg::B_Q_WALK: begin
				if (dj_q == dlast) begin
					dj_q <= '0;
					di_q <= di_q + 2'd1;
				end else begin
					dj_q <= dj_q + 2'd1;
				end
			end
			fha_pkg::B_EVAL: begin
				// An empty pixel keeps its plain average; a sparse one goes black.
				if (f_q == '0)
					g_q <= 9'd256;
				else
					g_q <= 9'd0;
			end
			fha_pkg::B_LOG_F: if (log_done) lf_q <= log_res;
			fha_pkg::B_LOG_D: if (log_done) ld_q <= log_res;
			fha_pkg::B_LOG_L: if (log_done) ll_q <= log_res;
			fha_pkg::B_RATIO: begin
				step_q <= '0;
				r_q    <= lm[fha_pkg::LOG_BITS-1:0];
				if (lm[fha_pkg::LOG_BITS] || lm == '0)
					a_q <= 9'd0;
				else if (lm[fha_pkg::LOG_BITS-1:0] >= ll_q)
					a_q <= 9'd256;
				else
					a_q <= 9'd0;
			end
			fha_pkg::B_DIV: begin
				r_q    <= rge ? fha_pkg::LOG_BITS'(r2 - {1'b0, ll_q}) : r2[fha_pkg::LOG_BITS-1:0];
				a_q    <= {a_q[7:0], rge};
				step_q <= step_q + 3'd1;
			end
			fha_pkg::B_GAMMA: g_q <= fha_pkg::GAMMA_TAB[a_q];
			fha_pkg::B_SCALE1: begin
				prod_r_s1 <= sum_r_q * g_q;
				prod_g_s1 <= sum_g_q * g_q;
				prod_b_s1 <= sum_b_q * g_q;
			end
			fha_pkg::B_SCALE2: begin
				pixel_red   <= tone_out(prod_r_s1, cfg.dens, dd);
				pixel_green <= tone_out(prod_g_s1, cfg.dens, dd);
				pixel_blue  <= tone_out(prod_b_s1, cfg.dens, dd);
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
